>>> sv/gbd_pkg.sv
`default_nettype none

package gbd_pkg;

    // Fixed widths of the interface words.
    localparam int WORD_BITS  = 32;
    localparam int COUNT_OUT_BITS = 16;

    // Population register width and number of fraction bits of the fixed-point values.
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // The logarithm in fixed point is below 32 << FRAC_BITS + 1, so it needs six integer bits.
    localparam int LN_BITS  = FRAC_BITS + 6;
    // Dividend of the waiting-time division is the logarithm shifted up by FRAC_BITS.
    localparam int DIV_BITS = LN_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
    localparam int SQ_CNT_BITS  = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

    // ln 2 in Q0.32.
    localparam logic [WORD_BITS-1:0] LN2_Q32 = 32'hB172_17F7;

    // Register reset values.
    localparam logic [WORD_BITS-1:0] BIRTH_RESET = WORD_BITS'(64'd2 << FRAC_BITS);
    localparam logic [WORD_BITS-1:0] DECAY_RESET =
        WORD_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [WORD_BITS-1:0] END_RESET   = WORD_BITS'(64'd100 << FRAC_BITS);

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BIRTH_RATE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_RATE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_TIME   = 2'd2;

    // Event kinds.
    localparam logic EVENT_BIRTH = 1'b0;
    localparam logic EVENT_DECAY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_REACT,
        ST_LOG,
        ST_DIV,
        ST_COMMIT
    } step_state_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_NORM,
        LN_SQUARE,
        LN_SCALE
    } ln_state_t;

endpackage

`default_nettype wire

>>> sv/gbd_ln.sv
`default_nettype none

// Natural log of 2^32/word in fixed point. The word is normalized in five
// binary shift steps, then one fraction bit of log2 is produced per squaring.
module gbd_ln
    import gbd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [WORD_BITS-1:0] word,
    output logic                      done,
    output logic [LN_BITS-1:0]        ln_q
);

    ln_state_t                state_reg, state_next;
    logic [2:0]               norm_step_reg;
    logic [SQ_CNT_BITS-1:0]   sq_cnt_reg;
    logic [WORD_BITS-1:0]     x_reg;
    logic [4:0]               shcnt_reg;
    logic [FRAC_BITS-1:0]     frac_reg;
    logic [LN_BITS-1:0]       ln_reg;
    logic                     done_reg;

    logic [4:0]               sh;
    logic [WORD_BITS-1:0]     top_mask;
    logic                     top_zero;
    logic [63:0]              sq_prod;
    logic [4:0]               lead;
    logic [FRAC_BITS+4:0]     lg;
    logic [LN_BITS-1:0]       l_val;
    logic [63:0]              ln_prod;

    assign sh       = 5'(5'd16 >> norm_step_reg);
    assign top_mask = ~(32'hFFFF_FFFF >> sh);
    assign top_zero = (x_reg & top_mask) == '0;
    assign sq_prod  = 64'(x_reg) * 64'(x_reg);
    assign lead     = 5'd31 - shcnt_reg;
    assign lg       = {lead, frac_reg};
    assign l_val    = (LN_BITS'(32) << FRAC_BITS) - LN_BITS'(lg);
    assign ln_prod  = 64'(l_val) * 64'(LN2_Q32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == LN_SCALE);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LN_IDLE:
            begin
                if (start)
                    state_next = LN_NORM;
            end
            LN_NORM:
            begin
                if (norm_step_reg == 3'd4)
                    state_next = LN_SQUARE;
            end
            LN_SQUARE:
            begin
                if (sq_cnt_reg == SQ_CNT_BITS'(FRAC_BITS - 1))
                    state_next = LN_SCALE;
            end
            LN_SCALE:
            begin
                state_next = LN_IDLE;
            end
            default:
            begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            LN_IDLE:
            begin
                x_reg         <= word;
                shcnt_reg     <= '0;
                norm_step_reg <= '0;
                sq_cnt_reg    <= '0;
            end
            LN_NORM:
            begin
                if (top_zero)
                begin
                    x_reg     <= x_reg << sh;
                    shcnt_reg <= shcnt_reg + sh;
                end
                norm_step_reg <= norm_step_reg + 3'd1;
            end
            LN_SQUARE:
            begin
                // The square is in [2^62, 2^64); its top bit decides the fraction bit.
                if (sq_prod[63])
                    x_reg <= sq_prod[63:32];
                else
                    x_reg <= sq_prod[62:31];
                frac_reg   <= {frac_reg[FRAC_BITS-2:0], sq_prod[63]};
                sq_cnt_reg <= sq_cnt_reg + SQ_CNT_BITS'(1);
            end
            LN_SCALE:
            begin
                ln_reg <= LN_BITS'(ln_prod >> 32);
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign ln_q = ln_reg;

endmodule

`default_nettype wire

>>> sv/gbd_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient shifts into
// the dividend register as the dividend shifts out. Saturates to 32 bits.
module gbd_div
    import gbd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_BITS-1:0]  dividend,
    input  wire logic [WORD_BITS-1:0] divisor,
    output logic                      done,
    output logic [WORD_BITS-1:0]      quotient
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_BITS-1:0]     num_reg;
    logic [WORD_BITS-1:0]    rem_reg;

    logic [WORD_BITS:0]      trial;
    logic                    ge;
    logic [WORD_BITS:0]      diff;
    logic                    last;

    assign trial = {rem_reg, num_reg[DIV_BITS-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};
    assign last  = cnt_reg == DIV_CNT_BITS'(DIV_BITS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_BITS'(1);
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_BITS-2:0], ge};
            rem_reg <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = (|num_reg[DIV_BITS-1:WORD_BITS]) ? '1 : num_reg[WORD_BITS-1:0];

endmodule

`default_nettype wire

>>> sv/gillespie_birth_death_step.sv
// One transaction at a time: a new input can be taken in the cycle after the step commits.
// A step whose end time is already reached goes straight to the result;
// a zero wait word or total rate bypasses the log and divide units.
// The log unit (FRAC_BITS squarings) and the bit-serial divider set the length of a step.
// Reset (rst_n, asynchronous, active low) clears time and population to zero and
// loads the registers with birth 2.0, decay 0.1 and end time 100.0 (Q16.16).
`default_nettype none

module gillespie_birth_death_step
    import gbd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [WORD_BITS-1:0]      cfg_data,

    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [WORD_BITS-1:0]      uniform_wait,
    input  wire logic [WORD_BITS-1:0]      uniform_pick,

    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [WORD_BITS-1:0]           sim_time,
    output logic [COUNT_OUT_BITS-1:0]      molecule_count,
    output logic                           event_kind,
    output logic                           finished
);

    // Configuration registers.
    logic [WORD_BITS-1:0]  birth_rate_reg;
    logic [WORD_BITS-1:0]  decay_rate_reg;
    logic [WORD_BITS-1:0]  end_time_reg;

    // Simulation state.
    logic [WORD_BITS-1:0]  time_reg;
    logic [COUNT_BITS-1:0] pop_reg;

    // Step control and working values.
    step_state_t           state_reg, state_next;
    logic [WORD_BITS-1:0]  u_wait_reg;
    logic [WORD_BITS-1:0]  u_pick_reg;
    logic [WORD_BITS-1:0]  total_reg;
    logic [WORD_BITS-1:0]  tau_reg;
    logic                  birth_reg;
    logic                  stop_reg;

    // Output register.
    logic                      out_valid_reg;
    logic [WORD_BITS-1:0]      out_time_reg;
    logic [COUNT_OUT_BITS-1:0] out_count_reg;
    logic                      out_kind_reg;
    logic                      out_fin_reg;

    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic                  ln_start;
    logic                  div_start;
    logic                  ln_done;
    logic [LN_BITS-1:0]    ln_q;
    logic                  div_done;
    logic [WORD_BITS-1:0]  div_quot;

    logic [WORD_BITS-1:0]  mul_a;
    logic [WORD_BITS-1:0]  mul_b;
    logic [63:0]           mul_prod;
    logic [63:0]           total_sum;
    logic [WORD_BITS:0]    time_sum;
    logic [WORD_BITS-1:0]  time_new;
    logic [COUNT_BITS-1:0] pop_new;
    logic                  skip_wait;

    // -----------------------------------------------------------------
    // Configuration writes. Indexes beyond the register list are dropped.
    // -----------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            birth_rate_reg <= BIRTH_RESET;
            decay_rate_reg <= DECAY_RESET;
            end_time_reg   <= END_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIRTH_RATE: birth_rate_reg <= cfg_data;
                REG_DECAY_RATE: decay_rate_reg <= cfg_data;
                REG_END_TIME:   end_time_reg   <= cfg_data;
                default:        birth_rate_reg <= birth_rate_reg;
            endcase
        end
    end

    // -----------------------------------------------------------------
    // Shared 32x32 multiplier. In the total-rate cycle it forms
    // decay * population; in the reaction cycle it forms pick * total.
    // -----------------------------------------------------------------
    assign mul_a     = (state_reg == ST_TOTAL) ? decay_rate_reg : u_pick_reg;
    assign mul_b     = (state_reg == ST_TOTAL) ? WORD_BITS'(pop_reg) : total_reg;
    assign mul_prod  = 64'(mul_a) * 64'(mul_b);
    assign total_sum = mul_prod + 64'(birth_rate_reg);

    // With a zero wait word or a zero total the waiting time saturates and
    // the log and divide units are bypassed.
    assign skip_wait = (u_wait_reg == '0) || (total_reg == '0);

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // -----------------------------------------------------------------
    // Step sequencer.
    // -----------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ln_start   = 1'b0;
        div_start  = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // A finished simulation goes straight to the result.
                    if (time_reg >= end_time_reg)
                        state_next = ST_COMMIT;
                    else
                        state_next = ST_TOTAL;
                end
            end
            ST_TOTAL:
            begin
                state_next = ST_REACT;
            end
            ST_REACT:
            begin
                if (skip_wait)
                    state_next = ST_COMMIT;
                else
                begin
                    ln_start   = 1'b1;
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (ln_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // Waits here while the previous result is still held.
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // -----------------------------------------------------------------
    // Working registers of the step.
    // -----------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_wait_reg <= uniform_wait;
            u_pick_reg <= uniform_pick;
        end
        case (state_reg)
            ST_TOTAL:
            begin
                // Exact sum, then saturated to one word.
                total_reg <= (|total_sum[63:32]) ? '1 : total_sum[WORD_BITS-1:0];
            end
            ST_REACT:
            begin
                // pick * total < birth << 32 compares the top word only.
                birth_reg <= mul_prod[63:32] < birth_rate_reg;
                tau_reg   <= '1;
            end
            ST_DIV:
            begin
                if (div_done)
                    tau_reg <= div_quot;
            end
            default:
            begin
                total_reg <= total_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stop_reg <= 1'b0;
        else if (accept)
            stop_reg <= time_reg >= end_time_reg;
    end

    // -----------------------------------------------------------------
    // Commit: time advance saturates at the top of the word, the count
    // saturates at both ends.
    // -----------------------------------------------------------------
    assign time_sum = {1'b0, time_reg} + {1'b0, tau_reg};
    assign time_new = time_sum[WORD_BITS] ? '1 : time_sum[WORD_BITS-1:0];

    always_comb
    begin
        pop_new = pop_reg;
        if (birth_reg)
        begin
            if (pop_reg != '1)
                pop_new = pop_reg + COUNT_BITS'(1);
        end
        else
        begin
            if (pop_reg != '0)
                pop_new = pop_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            pop_reg  <= '0;
        end
        else if (commit && !stop_reg)
        begin
            time_reg <= time_new;
            pop_reg  <= pop_new;
        end
    end

    // -----------------------------------------------------------------
    // Output register. It holds a result until its transaction completes,
    // while the next input transaction may already be taken.
    // -----------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            if (stop_reg)
            begin
                out_time_reg  <= time_reg;
                out_count_reg <= COUNT_OUT_BITS'(pop_reg);
                out_kind_reg  <= EVENT_BIRTH;
                out_fin_reg   <= 1'b1;
            end
            else
            begin
                out_time_reg  <= time_new;
                out_count_reg <= COUNT_OUT_BITS'(pop_new);
                out_kind_reg  <= birth_reg ? EVENT_BIRTH : EVENT_DECAY;
                out_fin_reg   <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign sim_time       = out_time_reg;
    assign molecule_count = out_count_reg;
    assign event_kind     = out_kind_reg;
    assign finished       = out_fin_reg;

    // -----------------------------------------------------------------
    // Arithmetic units.
    // -----------------------------------------------------------------
    gbd_ln u_ln (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ln_start),
        .word  (u_wait_reg),
        .done  (ln_done),
        .ln_q  (ln_q)
    );

    gbd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DIV_BITS'(ln_q) << FRAC_BITS),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

`ifndef SYNTH
    // A step that was not applied always reports the birth kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> event_kind == EVENT_BIRTH)
        else $error("finished result carries a decay kind");

    // Time and population only move when a step commits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(time_reg) && $stable(pop_reg))
        else $error("state changed outside a commit");

    // Simulation time never runs backwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> time_reg >= $past(time_reg))
        else $error("simulation time decreased");

    // The log unit only reports completion while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        ln_done |-> state_reg == ST_LOG)
        else $error("log unit finished outside the log wait");
`endif

endmodule

`default_nettype wire
